FILE: src/vcm_pkg.sv
// Shared types and constants for the velocity colour map block.
package vcm_pkg;

  // Selector codes carried with each input item
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_GATHER = 2'd1;
  localparam logic [1:0] FUNC_MAP    = 2'd2;

  // Colour channel width and quotient bits produced per division
  localparam int unsigned QUOT_WIDTH = 8;
  localparam logic [QUOT_WIDTH-1:0] CHAN_FULL = 8'd255;
  localparam logic [QUOT_WIDTH-1:0] CHAN_ZERO = 8'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CLAMP,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } vcm_state_e;

  // Control from the sequencer to the divider lanes
  typedef struct packed {
    logic load;
    logic step;
  } vcm_div_ctrl_t;

endpackage

FILE: src/vcm_div_lane.sv
// Bit-serial restoring divider lane: one quotient bit per step, quotient below 256.
module vcm_div_lane #(
  parameter int unsigned DIV_WIDTH = 16,
  parameter int unsigned NUM_WIDTH = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  vcm_pkg::vcm_div_ctrl_t             ctrl_i,
  input  logic [NUM_WIDTH-1:0]               num_i,
  input  logic [DIV_WIDTH-1:0]               div_i,
  output logic [vcm_pkg::QUOT_WIDTH-1:0]     quot_o
);

  logic [NUM_WIDTH-1:0]           rem_q, rem_d;
  logic [NUM_WIDTH-1:0]           dv_q, dv_d;
  logic [vcm_pkg::QUOT_WIDTH-1:0] quot_q, quot_d;
  logic [NUM_WIDTH:0]             diff;
  logic                           fits;

  // trial subtract of the divisor aligned to the current quotient bit
  assign diff = {1'b0, rem_q} - {1'b0, dv_q};
  assign fits = ~diff[NUM_WIDTH];

  always_comb begin
    rem_d  = rem_q;
    dv_d   = dv_q;
    quot_d = quot_q;
    if (ctrl_i.load) begin
      rem_d  = num_i;
      dv_d   = NUM_WIDTH'(div_i) << (vcm_pkg::QUOT_WIDTH - 1);
      quot_d = '0;
    end else if (ctrl_i.step) begin
      rem_d  = fits ? diff[NUM_WIDTH-1:0] : rem_q;
      dv_d   = dv_q >> 1;
      quot_d = {quot_q[vcm_pkg::QUOT_WIDTH-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dv_q   <= '0;
      quot_q <= '0;
    end else begin
      rem_q  <= rem_d;
      dv_q   <= dv_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

FILE: src/velocity_colour_map_core.sv
// Top level: min/max tracking and blue-green-red colour mapping of flow cells.
//
//  channel  | dir | tdata                       | tuser
//  s_axis   | in  | velocity                    | func[1:0], is_fluid[2]
//  m_axis   | out | blue[7:0] green[15:8] red[23:16] | -
//
// Clear, gather and unused items are taken in idle and leave the sequencer there.
// A map item is taken in idle, then passes three setup states (range, clamp,
// numerators), the divide steps of the two bit-serial divider lanes and a hand-off
// state that waits on the output register; no new item is taken until idle again.
// Reset sets minimum to the most positive and maximum to the most negative value.
// A finished pixel waits in the output register; only a second pixel stalls on it.
module velocity_colour_map_core #(
  parameter int unsigned VELOCITY_WIDTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // velocity, zero padded to whole bytes
  input  logic [((VELOCITY_WIDTH+7)/8)*8-1:0]       s_axis_tdata_i,
  // func[1:0], is_fluid[2]
  input  logic [2:0]                                s_axis_tuser_i,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  // blue[7:0], green[15:8], red[23:16]
  output logic [3*vcm_pkg::QUOT_WIDTH-1:0]          m_axis_tdata_o
);

  localparam int unsigned VW = VELOCITY_WIDTH;
  localparam int unsigned NW = VELOCITY_WIDTH + 9;
  localparam int unsigned QW = vcm_pkg::QUOT_WIDTH;
  localparam logic signed [VW-1:0] VEL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VEL_MIN = {1'b1, {(VW-1){1'b0}}};

  vcm_pkg::vcm_state_e state_q, state_d;

  logic                   in_acc;
  logic [1:0]             in_func;
  logic                   in_fluid;
  logic signed [VW-1:0]   in_vel;

  logic signed [VW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic signed [VW-1:0]   vel_q;
  logic                   fluid_q;
  logic signed [VW:0]     rs_q, ds_q;
  logic [VW-1:0]          r_q, d_q;
  logic                   lower_q, empty_q;
  logic [2:0]             cnt_q;

  logic [VW-1:0]          d_clamp;
  logic [VW:0]            x_a, x_b;
  logic [NW-1:0]          ext_a, ext_b, num_a, num_b;
  logic [QW-1:0]          quot_a, quot_b;

  logic                   out_load;
  logic                   m_valid_q;
  logic [3*QW-1:0]        m_data_q, m_data_d;
  vcm_pkg::vcm_div_ctrl_t div_ctrl;

  assign in_func  = s_axis_tuser_i[1:0];
  assign in_fluid = s_axis_tuser_i[2];
  assign in_vel   = s_axis_tdata_i[VW-1:0];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vcm_pkg::ST_IDLE: begin
        if (in_acc && in_func == vcm_pkg::FUNC_MAP) state_d = vcm_pkg::ST_DIFF;
      end
      vcm_pkg::ST_DIFF:  state_d = vcm_pkg::ST_CLAMP;
      vcm_pkg::ST_CLAMP: state_d = vcm_pkg::ST_LOAD;
      vcm_pkg::ST_LOAD:  state_d = vcm_pkg::ST_DIV;
      vcm_pkg::ST_DIV: begin
        if (cnt_q == 3'd7) state_d = vcm_pkg::ST_DONE;
      end
      vcm_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) state_d = vcm_pkg::ST_IDLE;
      end
      default: state_d = vcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    div_ctrl        = '0;
    out_load        = 1'b0;
    unique case (state_q)
      vcm_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      vcm_pkg::ST_LOAD: div_ctrl.load = 1'b1;
      vcm_pkg::ST_DIV:  div_ctrl.step = 1'b1;
      vcm_pkg::ST_DONE: out_load = !m_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcm_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (div_ctrl.load)      cnt_q <= '0;
      else if (div_ctrl.step) cnt_q <= cnt_q + 3'd1;
    end
  end

  // ---------------- statistics ----------------
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (in_acc) begin
      if (in_func == vcm_pkg::FUNC_CLEAR) begin
        lo_d = VEL_MAX;
        hi_d = VEL_MIN;
      end else if (in_func == vcm_pkg::FUNC_GATHER && in_fluid) begin
        if (in_vel < lo_q) lo_d = in_vel;
        if (in_vel > hi_q) hi_d = in_vel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= VEL_MAX;
      hi_q <= VEL_MIN;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // ---------------- map datapath ----------------
  always_comb begin
    if (ds_q < 0)          d_clamp = '0;
    else if (ds_q > rs_q)  d_clamp = rs_q[VW-1:0];
    else                   d_clamp = ds_q[VW-1:0];
  end

  // lower half: blue = 255(r-2d)/r, green = 510d/r
  // upper half: green = 510(r-d)/r, red = 255(2d-r)/r
  always_comb begin
    if (lower_q) begin
      x_a = {1'b0, r_q} - {d_q, 1'b0};
      x_b = {1'b0, d_q};
    end else begin
      x_a = {1'b0, r_q} - {1'b0, d_q};
      x_b = {d_q, 1'b0} - {1'b0, r_q};
    end
    ext_a = NW'(x_a);
    ext_b = NW'(x_b);
    num_a = lower_q ? (ext_a << 8) - ext_a : (ext_a << 9) - (ext_a << 1);
    num_b = lower_q ? (ext_b << 9) - (ext_b << 1) : (ext_b << 8) - ext_b;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vel_q   <= in_vel;
      fluid_q <= in_fluid;
    end
    if (state_q == vcm_pkg::ST_DIFF) begin
      rs_q <= {hi_q[VW-1], hi_q} - {lo_q[VW-1], lo_q};
      ds_q <= {vel_q[VW-1], vel_q} - {lo_q[VW-1], lo_q};
    end
    if (state_q == vcm_pkg::ST_CLAMP) begin
      empty_q <= (rs_q <= 0);
      r_q     <= rs_q[VW-1:0];
      d_q     <= d_clamp;
      lower_q <= ({d_clamp, 1'b0} <= {1'b0, rs_q[VW-1:0]});
    end
  end

  vcm_div_lane #(
    .DIV_WIDTH (VW),
    .NUM_WIDTH (NW)
  ) u_lane_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (num_a),
    .div_i  (r_q),
    .quot_o (quot_a)
  );

  vcm_div_lane #(
    .DIV_WIDTH (VW),
    .NUM_WIDTH (NW)
  ) u_lane_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (num_b),
    .div_i  (r_q),
    .quot_o (quot_b)
  );

  // ---------------- output register ----------------
  always_comb begin
    if (!fluid_q)     m_data_d = {vcm_pkg::CHAN_ZERO, vcm_pkg::CHAN_ZERO, vcm_pkg::CHAN_ZERO};
    else if (empty_q) m_data_d = {vcm_pkg::CHAN_ZERO, vcm_pkg::CHAN_ZERO, vcm_pkg::CHAN_FULL};
    else if (lower_q) m_data_d = {vcm_pkg::CHAN_ZERO, quot_b, quot_a};
    else              m_data_d = {quot_b, quot_a, vcm_pkg::CHAN_ZERO};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
